@@ design/rmf_pkg.sv @@
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types, widths and constants of the running median filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int MaxWindow = 16;
  localparam int SampleW   = 16;
  localparam int WsW       = 5;
  localparam int CntW      = $clog2(MaxWindow + 1);
  localparam int AgeW      = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int IdxW      = AgeW;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 16;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [AgeW-1:0]           age_t;
  typedef logic [CntW-1:0]           cnt_t;
  typedef logic [WsW-1:0]            wsize_t;
  typedef logic [IdxW-1:0]           idx_t;

  localparam wsize_t  WsReset   = wsize_t'(16);
  localparam sample_t FillReset = sample_t'(0);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_FILL_VALUE  = 1'b1
  } cfg_addr_e;

  // per-cell control from the top level
  typedef struct packed {
    logic go;
    logic init;
    logic active;
    logic in_sort;
    logic is_ins;
    logic at_or_above;
    logic at_or_below;
    logic up_case;
    logic has_up;
    logic has_dn;
  } cell_ctl_t;

  // what a cell shows its neighbors and the top level
  typedef struct packed {
    sample_t sample;
    age_t    age_dec;
    logic    gt;
    logic    zero;
  } cell_st_t;

endpackage

@@ design/rmf_if.sv @@
// ----------------------------------------------------------------------------
// rmf_if
// Valid/ready channels for input samples and median results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rmf_sample_if;
  import rmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmf_median_if;
  import rmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

@@ design/rmf_cell.sv @@
// ----------------------------------------------------------------------------
// rmf_cell
// One window entry: sample and age, with compare, age count-down and a
// shift toward either neighbor while the new item settles into sorted place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmf_pkg::cell_ctl_t ctl_i,
  input  rmf_pkg::sample_t   new_sample_i,
  input  rmf_pkg::age_t      new_age_i,
  input  rmf_pkg::sample_t   fill_i,
  input  rmf_pkg::cell_st_t  dn_i,
  input  rmf_pkg::cell_st_t  up_i,
  output rmf_pkg::cell_st_t  st_o
);
  import rmf_pkg::*;

  sample_t sample_q, sample_d;
  age_t    age_q, age_d;
  age_t    age_dec;
  logic    gt;

  assign gt      = sample_q > new_sample_i;
  assign age_dec = (ctl_i.active && (age_q != '0)) ? age_t'(age_q - 1'b1) : age_q;

  assign st_o.sample  = sample_q;
  assign st_o.age_dec = age_dec;
  assign st_o.gt      = gt;
  assign st_o.zero    = ctl_i.active && (age_q == '0);

  always_comb begin
    sample_d = sample_q;
    age_d    = age_q;
    if (ctl_i.init) begin
      sample_d = fill_i;
      age_d    = '0;
    end else if (ctl_i.go && ctl_i.active) begin
      age_d = age_dec;
      if (ctl_i.up_case && ctl_i.at_or_above) begin
        if (ctl_i.has_up && !up_i.gt) begin
          sample_d = up_i.sample;
          age_d    = up_i.age_dec;
        end else if (!ctl_i.is_ins && ctl_i.in_sort && !gt) begin
          sample_d = new_sample_i;
          age_d    = new_age_i;
        end
      end else if (!ctl_i.up_case && ctl_i.at_or_below) begin
        if (ctl_i.has_dn && dn_i.gt) begin
          sample_d = dn_i.sample;
          age_d    = dn_i.age_dec;
        end else if (ctl_i.is_ins || gt) begin
          sample_d = new_sample_i;
          age_d    = new_age_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= FillReset;
      age_q    <= '0;
    end else begin
      sample_q <= sample_d;
      age_q    <= age_d;
    end
  end

endmodule

@@ design/rmf_median.sv @@
// ----------------------------------------------------------------------------
// rmf_median
// Median select over the sorted window: middle entry, or the floor mean of
// the middle pair, into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmf_median (
  input  logic                                      clk_i,
  input  logic                                      load_i,
  input  rmf_pkg::sample_t [rmf_pkg::MaxWindow-1:0] win_i,
  input  rmf_pkg::cnt_t                             cnt_i,
  output rmf_pkg::sample_t                          median_o
);
  import rmf_pkg::*;

  idx_t                   hi_idx;
  idx_t                   lo_idx;
  logic signed [SampleW:0] sum;
  sample_t                median_q;

  assign hi_idx = idx_t'(cnt_i >> 1);
  assign lo_idx = cnt_i[0] ? hi_idx : idx_t'(hi_idx - idx_t'(1));
  assign sum    = {win_i[lo_idx][SampleW-1], win_i[lo_idx]}
                + {win_i[hi_idx][SampleW-1], win_i[hi_idx]};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      median_q <= sum[SampleW:1];
    end
  end

  assign median_o = median_q;

endmodule

@@ design/running_median_filter.sv @@
// ----------------------------------------------------------------------------
// running_median_filter
// An accepted item first updates the cell row, then its median is loaded
// into the result register and offered. Throughput: one item per cycle
// unless the median output stalls; the cell row sorts the window at once.
// Reset: window size 16, fill value 0, store empty; a register write reloads
// every entry with the prior fill value and clears ages and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_median_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rmf_pkg::CfgDataW-1:0]  cfg_data_i,
  rmf_sample_if.sink                    sample_i,
  rmf_median_if.source                  median_o
);
  import rmf_pkg::*;

  wsize_t  ws_q;
  sample_t fill_q;
  cnt_t    fill_cnt_q;
  logic    pend_q;
  logic    out_valid_q;

  cnt_t    size;
  cnt_t    n_new;
  age_t    new_age;
  logic    in_fire;
  logic    load_out;
  logic    found;
  logic    up_case;
  sample_t median;

  cell_ctl_t                  ctl     [MaxWindow];
  cell_st_t                   st      [MaxWindow];
  cell_st_t                   dn_st   [MaxWindow];
  cell_st_t                   up_st   [MaxWindow];
  logic [MaxWindow-1:0]       zvec;
  logic [MaxWindow-1:0]       zbelow;
  logic [MaxWindow-1:0]       is_ins;
  logic [MaxWindow-1:0]       has_up;
  logic [MaxWindow-1:0]       up_ok;
  sample_t [MaxWindow-1:0]    win;

  always_comb begin
    if (ws_q == '0) begin
      size = cnt_t'(1);
    end else if (int'(ws_q) > MaxWindow) begin
      size = cnt_t'(MaxWindow);
    end else begin
      size = cnt_t'(ws_q);
    end
  end

  assign new_age  = age_t'(size - cnt_t'(1));
  assign n_new    = (fill_cnt_q < size) ? cnt_t'(fill_cnt_q + cnt_t'(1)) : fill_cnt_q;
  assign in_fire  = sample_i.valid && sample_i.ready;
  assign load_out = pend_q && (!out_valid_q || median_o.ready);
  assign found    = |zvec;
  assign up_case  = |(is_ins & up_ok);

  assign sample_i.ready = !pend_q || load_out;
  assign median_o.valid = out_valid_q;
  assign median_o.median = median;

  for (genvar p = 0; p < MaxWindow; p++) begin : g_cell
    localparam cnt_t PIdx  = cnt_t'(p);
    localparam cnt_t PNext = cnt_t'(p + 1);

    assign zvec[p]   = st[p].zero;
    assign is_ins[p] = zvec[p] && !zbelow[p];
    assign has_up[p] = PNext < n_new;
    assign win[p]    = st[p].sample;

    if (p == 0) begin : g_first
      assign zbelow[p] = 1'b0;
      assign dn_st[p]  = '0;
    end else begin : g_rest
      assign zbelow[p] = |zvec[p-1:0];
      assign dn_st[p]  = st[p-1];
    end

    if (p == MaxWindow - 1) begin : g_last
      assign up_st[p] = '0;
      assign up_ok[p] = 1'b0;
    end else begin : g_inner
      assign up_st[p] = st[p+1];
      assign up_ok[p] = has_up[p] && !st[p+1].gt;
    end

    assign ctl[p].go          = in_fire;
    assign ctl[p].init        = cfg_we_i;
    assign ctl[p].active      = PIdx < size;
    assign ctl[p].in_sort     = PIdx < n_new;
    assign ctl[p].is_ins      = is_ins[p];
    assign ctl[p].at_or_above = zbelow[p] || zvec[p];
    assign ctl[p].at_or_below = found && !zbelow[p];
    assign ctl[p].up_case     = up_case;
    assign ctl[p].has_up      = has_up[p];
    assign ctl[p].has_dn      = (p != 0);

    rmf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl[p]),
      .new_sample_i (sample_i.sample),
      .new_age_i    (new_age),
      .fill_i       (fill_q),
      .dn_i         (dn_st[p]),
      .up_i         (up_st[p]),
      .st_o         (st[p])
    );
  end

  rmf_median u_median (
    .clk_i    (clk_i),
    .load_i   (load_out),
    .win_i    (win),
    .cnt_i    (fill_cnt_q),
    .median_o (median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= WsReset;
      fill_q <= FillReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_e'(cfg_idx_i))
        CFG_WINDOW_SIZE: ws_q   <= cfg_data_i[WsW-1:0];
        CFG_FILL_VALUE:  fill_q <= sample_t'(cfg_data_i[SampleW-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fill_cnt_q <= '0;
      end else if (in_fire) begin
        fill_cnt_q <= n_new;
      end
      if (in_fire) begin
        pend_q <= 1'b1;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (median_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // at most one entry is replaced per item
  a_one_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> $onehot0(is_ins))
    else $error("more than one entry selected for replacement");

  // count never runs past the effective window
  a_cnt_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt_q <= size)
    else $error("fill count exceeds window size");

  // an accepted item always leaves work pending for the median stage
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> pend_q)
    else $error("accepted item not pending");

  // a register write empties the store
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (fill_cnt_q == '0))
    else $error("fill count not cleared by register write");

  // count grows by at most one per item
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i) |=>
      (fill_cnt_q == $past(fill_cnt_q)) ||
      (fill_cnt_q == cnt_t'($past(fill_cnt_q) + cnt_t'(1))))
    else $error("fill count stepped by more than one");

endmodule

@@ dv/running_median_filter_tb.sv @@
// ----------------------------------------------------------------------------
// running_median_filter_tb
// Drives signed samples into the running median filter and checks every
// median against a sorted-window predictor kept in step with the block or
// against the expected value of a short directed table, which covers the
// extremes, window size zero and saturation, the rounding of even counts,
// equal values and the fill value. Random phases follow, some with new
// window or fill settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_median_filter_tb;
  import rmf_pkg::*;

  localparam int RandItems  = 1700;
  localparam int WatchLimit = 1000;
  localparam int SettleCyc  = 4;
  localparam int DirN       = 27;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    cfg_addr_e            addr;
    logic [CfgDataW-1:0]  data;
    logic                 has_exp;
    sample_t              exp_med;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rmf_sample_if smp_if ();
  rmf_median_if med_if ();

  running_median_filter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (smp_if),
    .median_o   (med_if)
  );

  // window model
  sample_t     win_val [MaxWindow];
  age_t        win_age [MaxWindow];
  int unsigned win_cnt;
  wsize_t      cfg_wsize;
  sample_t     cfg_fill;

  sample_t     median_q [$];
  int unsigned err_cnt;
  int unsigned n_in;
  int unsigned n_out;
  int unsigned n_wr;
  int unsigned n_pause;
  int unsigned idle_cyc;
  bit          gap_on;
  bit          stall_on;

  dir_row_t dir_tbl [DirN] = '{
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h0064, 1'b1, 16'h0064},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h8000, 1'b1, 16'hC032},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h7FFF, 1'b1, 16'h0064},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h7FFF, 1'b1, 16'h4031},
    // only the low bits carry the window size
    '{ROW_CFG,    CFG_WINDOW_SIZE, 16'hFFE1, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'hFFFB, 1'b1, 16'hFFFB},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h0007, 1'b1, 16'h0007},
    // window size zero acts as one
    '{ROW_CFG,    CFG_WINDOW_SIZE, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h8000, 1'b1, 16'h8000},
    // oversized window saturates, even count rounds down
    '{ROW_CFG,    CFG_WINDOW_SIZE, 16'h001F, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'hFFFE, 1'b1, 16'hFFFE},
    // fill value stays out of the median, equal values
    '{ROW_CFG,    CFG_FILL_VALUE,  16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h0005, 1'b1, 16'h0005},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h0005, 1'b1, 16'h0005},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h0005, 1'b1, 16'h0005},
    '{ROW_CFG,    CFG_FILL_VALUE,  16'h7FFF, 1'b0, 16'h0000},
    '{ROW_CFG,    CFG_WINDOW_SIZE, 16'h0002, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h7FFF, 1'b1, 16'hFFFF},
    '{ROW_CFG,    CFG_WINDOW_SIZE, 16'h0011, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h0003, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'h0002, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_WINDOW_SIZE, 16'hFFFD, 1'b0, 16'h0000}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reload_window();
    for (int i = 0; i < MaxWindow; i++) begin
      win_val[i] = cfg_fill;
      win_age[i] = '0;
    end
    win_cnt = 0;
  endfunction

  function automatic void apply_cfg(cfg_addr_e addr, logic [CfgDataW-1:0] data);
    case (addr)
      CFG_WINDOW_SIZE: cfg_wsize = data[WsW-1:0];
      CFG_FILL_VALUE:  cfg_fill  = sample_t'(data);
      default: ;
    endcase
    reload_window();
  endfunction

  function automatic void swap_down(int p);
    sample_t tv;
    age_t    ta;
    tv           = win_val[p];
    ta           = win_age[p];
    win_val[p]   = win_val[p-1];
    win_age[p]   = win_age[p-1];
    win_val[p-1] = tv;
    win_age[p-1] = ta;
  endfunction

  // replace the oldest entry, re-sort, and pick the median
  function automatic sample_t median_step(sample_t s);
    int size;
    int ins;
    int half;
    int sum;
    bit moved;
    if (cfg_wsize == 0) size = 1;
    else if (cfg_wsize > MaxWindow) size = MaxWindow;
    else size = int'(cfg_wsize);
    ins   = size;
    moved = 1'b0;
    for (int p = 0; p < size; p++) begin
      if (win_age[p] != 0) begin
        win_age[p] = win_age[p] - 1'b1;
      end else if (ins == size) begin
        ins        = p;
        win_val[p] = s;
        win_age[p] = age_t'(size - 1);
      end
    end
    if (ins >= size) ins = size - 1;
    if (win_cnt < size) win_cnt++;
    for (int p = ins + 1; p < int'(win_cnt); p++) begin
      if (win_val[p-1] < win_val[p]) break;
      swap_down(p);
      moved = 1'b1;
    end
    if (!moved) begin
      for (int p = ins; p > 0; p--) begin
        if (win_val[p] < win_val[p-1]) swap_down(p);
      end
    end
    half = int'(win_cnt >> 1);
    if (win_cnt[0]) return win_val[half];
    sum = int'(win_val[half-1]) + int'(win_val[half]);
    return sample_t'(sum >>> 1);
  endfunction

  function automatic sample_t draw_sample(sample_t base);
    case ($urandom_range(0, 15))
      0:             return sample_t'(16'h8000);
      1:             return sample_t'(16'h7FFF);
      2, 3, 4, 5, 6: return base + sample_t'($urandom_range(0, 3));
      default:       return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t s, input bit typed, input sample_t typed_med);
    int unsigned gap;
    sample_t     pred;
    gap = gap_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
    pred = median_step(s);
    median_q.push_back(typed ? typed_med : pred);
    n_in++;
  endtask

  // stop sending and let every pending median come out
  task automatic drain();
    smp_if.valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_addr_e addr, input logic [CfgDataW-1:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    apply_cfg(addr, data);
    n_wr++;
  endtask

  // median receiver
  initial begin
    int unsigned stall;
    sample_t     exp_med;
    med_if.ready <= 1'b0;
    stall_on = 1'b1;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) stall_on = !stall_on;
      stall = stall_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        med_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      med_if.ready <= 1'b1;
      do @(posedge clk_i); while (!med_if.valid);
      n_out++;
      if (median_q.size() == 0) begin
        $display("%0t: median with no item pending: expected none, got %0d",
                 $time, med_if.median);
        err_cnt++;
      end else begin
        exp_med = median_q.pop_front();
        if (med_if.median !== exp_med) begin
          $display("%0t: median mismatch: expected %0d, got %0d",
                   $time, exp_med, med_if.median);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (med_if.valid && med_if.ready)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WatchLimit) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, WatchLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned         n_phase;
    int unsigned         len;
    int unsigned         pause_at;
    wsize_t              ws;
    logic [CfgDataW-1:0] wd;
    sample_t             base;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_WINDOW_SIZE;
    cfg_data_i    <= '0;
    smp_if.valid  <= 1'b0;
    smp_if.sample <= '0;
    err_cnt       = 0;
    n_in          = 0;
    n_out         = 0;
    n_wr          = 0;
    n_pause       = 0;
    n_phase       = 0;
    gap_on        = 1'b1;
    cfg_wsize     = WsReset;
    cfg_fill      = FillReset;
    reload_window();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].kind == ROW_CFG) begin
        write_reg(dir_tbl[k].addr, dir_tbl[k].data);
      end else begin
        send_sample(sample_t'(dir_tbl[k].data), dir_tbl[k].has_exp, dir_tbl[k].exp_med);
      end
    end

    while (n_in < DirN + RandItems) begin
      n_phase++;
      case ($urandom_range(0, 9))
        0:          ws = '0;
        1:          ws = wsize_t'(1);
        2:          ws = wsize_t'(MaxWindow);
        3:          ws = wsize_t'($urandom_range(MaxWindow + 1, 31));
        default:    ws = wsize_t'($urandom_range(1, MaxWindow));
      endcase
      wd              = CfgDataW'($urandom);
      wd[WsW-1:0]     = ws;
      case ($urandom_range(0, 3))
        0: write_reg(CFG_WINDOW_SIZE, wd);
        1: write_reg(CFG_FILL_VALUE, CfgDataW'($urandom));
        2: begin
          write_reg(CFG_FILL_VALUE, $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
          write_reg(CFG_WINDOW_SIZE, wd);
        end
        default: ;
      endcase
      gap_on   = $urandom_range(0, 3) != 0;
      base     = sample_t'($urandom);
      len      = $urandom_range(20, 120);
      pause_at = (n_phase == 2 || $urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : 0;
      for (int i = 0; i < len; i++) begin
        if (pause_at != 0 && i == pause_at) begin
          drain();
          n_pause++;
        end
        send_sample(draw_sample(base), 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d samples in, %0d medians out, %0d phases", n_in, n_out, n_phase);
    $display("summary: %0d register writes, %0d mid-phase drains, %0d errors",
             n_wr, n_pause, err_cnt);
    if (err_cnt == 0 && median_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
